[design/lpht_pkg.sv]
// Shared constants and control/status types for the linear-probe hash table.
package lpht_pkg;

  localparam int CAPACITY_DEF = 128;

  localparam int FUNC_W   = 2;
  localparam int KEY_W    = 16;
  localparam int VAL_W    = 32;
  localparam int POS_W    = 7;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 8;

  localparam logic [FUNC_W-1:0] FUNC_SET   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_GET   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_NEXT  = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic latch;     // capture input beat, first modulo multiply
    logic mul;       // second modulo multiply
    logic issue;     // home slot read
    logic check;     // examine slot data, probe on or finish
    logic clr;       // clear one slot
    logic load_out;  // move result into output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic skip;  // next on empty table, answer without reading
    logic more;  // probe continues at the following slot
    logic last;  // slot index at the last slot
  } sts_t;

endpackage

[design/lpht_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/lpht_ctrl.sv]
// Controller state machine: sequences modulo, probe, clear sweep and result handoff.
module lpht_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [lpht_pkg::FUNC_W-1:0] in_func,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output lpht_pkg::cmd_t              cmd,
  input  lpht_pkg::sts_t              sts
);

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_ISSUE = 3'd3;
  localparam logic [2:0] S_CHECK = 3'd4;
  localparam logic [2:0] S_CLR   = 3'd5;
  localparam logic [2:0] S_RESP  = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       m_tvalid_next;
  logic       out_free;

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_INIT: begin
        cmd.clr = 1'b1;
        if (sts.last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.latch = 1'b1;
          state_next = (in_func == lpht_pkg::FUNC_CLEAR) ? S_CLR : S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_ISSUE;
      end
      S_ISSUE: begin
        cmd.issue  = 1'b1;
        state_next = sts.skip ? S_RESP : S_CHECK;
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        if (!sts.more) begin
          state_next = S_RESP;
        end
      end
      S_CLR: begin
        cmd.clr = 1'b1;
        if (sts.last) begin
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    m_tvalid_next = m_tvalid;
    if (cmd.load_out) begin
      m_tvalid_next = 1'b1;
    end else if (m_tready) begin
      m_tvalid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_INIT;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= m_tvalid_next;
    end
  end

endmodule

[design/lpht_dp.sv]
// Datapath: home-slot modulo unit, slot RAM, probe index, entry count and result registers.
module lpht_dp #(
  parameter int CAPACITY = lpht_pkg::CAPACITY_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  lpht_pkg::cmd_t                cmd,
  output lpht_pkg::sts_t                sts,
  input  logic [lpht_pkg::FUNC_W-1:0]   in_func,
  input  logic [lpht_pkg::KEY_W-1:0]    in_key,
  input  logic [lpht_pkg::VAL_W-1:0]    in_value,
  input  logic [lpht_pkg::POS_W-1:0]    in_position,
  output logic [lpht_pkg::STATUS_W-1:0] out_status,
  output logic                          out_found,
  output logic [lpht_pkg::VAL_W-1:0]    out_value,
  output logic [lpht_pkg::KEY_W-1:0]    out_key,
  output logic [lpht_pkg::POS_W-1:0]    out_next_position,
  output logic                          out_scan_done,
  output logic [lpht_pkg::COUNT_W-1:0]  out_entry_count
);

  localparam int KW = lpht_pkg::KEY_W;
  localparam int VW = lpht_pkg::VAL_W;
  localparam int PW = lpht_pkg::POS_W;
  localparam int NW = lpht_pkg::COUNT_W;
  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int WW = 1 + KW + VW;
  localparam int RW = 32;

  localparam logic [IW-1:0] LAST_SLOT = IW'(CAPACITY - 1);
  // ceil(2^32 / CAPACITY): exact quotient for any 16-bit operand
  localparam logic [63:0] RECIP64 =
    ((64'd1 << 32) + 64'(CAPACITY) - 64'd1) / 64'(CAPACITY);
  localparam logic [RW-1:0] RECIP = RECIP64[RW-1:0];
  localparam logic [KW-1:0] CAP_K = KW'(CAPACITY);
  localparam logic [CW+2:0] LOAD_LIMIT = (CW + 3)'(3 * CAPACITY);

  logic [lpht_pkg::FUNC_W-1:0] func_q;
  logic [KW-1:0]               key_q;
  logic [VW-1:0]               value_q;
  logic [KW-1:0]               op_q;
  logic [KW-1:0]               quo_q;
  logic [KW-1:0]               prod_q;
  logic [IW-1:0]               idx;
  logic [IW-1:0]               idx_next;
  logic [CW-1:0]               count;
  logic [CW-1:0]               count_next;

  logic [lpht_pkg::STATUS_W-1:0] res_status;
  logic                          res_found;
  logic [VW-1:0]                 res_value;
  logic [KW-1:0]                 res_key;
  logic [PW-1:0]                 res_npos;
  logic                          res_done;

  logic [lpht_pkg::STATUS_W-1:0] res_status_next;
  logic                          res_found_next;
  logic [VW-1:0]                 res_value_next;
  logic [KW-1:0]                 res_key_next;
  logic [PW-1:0]                 res_npos_next;
  logic                          res_done_next;
  logic                          res_load;

  logic [KW-1:0]      op_in;
  logic [KW+RW-1:0]   recip_prod;
  logic [KW-1:0]      home_full;
  logic [IW-1:0]      home;
  logic [IW-1:0]      idx_inc;
  logic [WW-1:0]      rdata;
  logic [WW-1:0]      wdata;
  logic               we;
  logic               re;
  logic [IW-1:0]      raddr;
  logic               rd_occ;
  logic [KW-1:0]      rd_key;
  logic [VW-1:0]      rd_val;
  logic               hit;
  logic               full;
  logic               finish;
  logic               wr_slot;
  logic               probe_more;

  assign op_in      = (in_func == lpht_pkg::FUNC_NEXT) ? KW'(in_position) : in_key;
  assign recip_prod = (KW + RW)'(op_in) * (KW + RW)'(RECIP);
  assign home_full  = op_q - prod_q;
  assign home       = home_full[IW-1:0];
  assign idx_inc    = (idx == LAST_SLOT) ? '0 : idx + IW'(1);

  assign rd_occ = rdata[WW-1];
  assign rd_key = rdata[VW +: KW];
  assign rd_val = rdata[VW-1:0];
  assign hit    = rd_occ && (rd_key == key_q);
  assign full   = ({3'b000, count} + (CW + 3)'(1)) * (CW + 3)'(4) > LOAD_LIMIT;

  always_comb begin
    unique case (func_q)
      lpht_pkg::FUNC_SET,
      lpht_pkg::FUNC_GET:  probe_more = rd_occ && !hit;
      lpht_pkg::FUNC_NEXT: probe_more = !rd_occ && (idx != LAST_SLOT);
      default:             probe_more = 1'b0;
    endcase
  end
  assign sts.more = probe_more;
  assign sts.skip = (func_q == lpht_pkg::FUNC_NEXT) && (count == '0);
  assign sts.last = (idx == LAST_SLOT);

  assign finish  = cmd.check && !sts.more;
  assign wr_slot = finish && (func_q == lpht_pkg::FUNC_SET) && (hit || !full);

  assign we    = cmd.clr || wr_slot;
  assign wdata = {!cmd.clr, key_q, value_q};
  assign re    = cmd.issue || (cmd.check && sts.more);
  assign raddr = cmd.issue ? home : idx_inc;

  lpht_ram #(
    .WIDTH (WW),
    .DEPTH (CAPACITY)
  ) u_slots (
    .clk   (clk),
    .we    (we),
    .waddr (idx),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    idx_next   = idx;
    count_next = count;
    if (cmd.latch) begin
      idx_next = '0;
    end else if (cmd.issue) begin
      idx_next = home;
    end else if ((cmd.check && sts.more) || cmd.clr) begin
      idx_next = idx_inc;
    end
    if (cmd.clr && sts.last) begin
      count_next = '0;
    end else if (wr_slot && !hit) begin
      count_next = count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx   <= '0;
      count <= '0;
    end else begin
      idx   <= idx_next;
      count <= count_next;
    end
  end

  assign res_load = (cmd.clr && sts.last) || (cmd.issue && sts.skip) || finish;

  always_comb begin
    res_status_next = lpht_pkg::ST_OK;
    res_found_next  = 1'b0;
    res_value_next  = '0;
    res_key_next    = '0;
    res_npos_next   = '0;
    res_done_next   = 1'b0;
    if (cmd.issue) begin
      res_status_next = lpht_pkg::ST_MISS;
      res_done_next   = 1'b1;
    end else if (finish) begin
      unique case (func_q)
        lpht_pkg::FUNC_SET: begin
          if (!hit && full) begin
            res_status_next = lpht_pkg::ST_FULL;
          end
        end
        lpht_pkg::FUNC_GET: begin
          if (hit) begin
            res_found_next = 1'b1;
            res_value_next = rd_val;
            res_key_next   = key_q;
          end else begin
            res_status_next = lpht_pkg::ST_MISS;
          end
        end
        lpht_pkg::FUNC_NEXT: begin
          if (rd_occ) begin
            res_found_next = 1'b1;
            res_value_next = rd_val;
            res_key_next   = rd_key;
            res_npos_next  = PW'(idx_inc);
            res_done_next  = (idx_inc == '0);
          end else begin
            res_status_next = lpht_pkg::ST_MISS;
            res_done_next   = 1'b1;
          end
        end
        default: begin
          res_status_next = lpht_pkg::ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func_q  <= in_func;
      key_q   <= in_key;
      value_q <= in_value;
      op_q    <= op_in;
      quo_q   <= recip_prod[KW+RW-1 -: KW];
    end
    if (cmd.mul) begin
      prod_q <= KW'(quo_q * CAP_K);
    end

    if (res_load) begin
      res_status <= res_status_next;
      res_found  <= res_found_next;
      res_value  <= res_value_next;
      res_key    <= res_key_next;
      res_npos   <= res_npos_next;
      res_done   <= res_done_next;
    end

    if (cmd.load_out) begin
      out_status        <= res_status;
      out_found         <= res_found;
      out_value         <= res_value;
      out_key           <= res_key;
      out_next_position <= res_npos;
      out_scan_done     <= res_done;
      out_entry_count   <= NW'(count);
    end
  end

endmodule

[design/linear_probe_hash_table.sv]
// Top level of the linear-probe hash table: stream ports, controller and datapath.
//
//  channel | dir | tdata                                      | tuser              | tlast
//  s_      | in  | key[15:0] value[47:16] position[54:48]      | func[1:0]          | -
//  m_      | out | value_out[31:0] key_out[47:32]             | status[1:0]        | scan_done
//          |     | next_position[54:48] entry_count[62:55]    | found[2]           |
//
// Set and get read the home slot and probe the slots after it; next scans
// from the given position to the next occupied slot; clear sweeps every
// slot. The slot RAM, with one write and one read port, reads one slot per cycle.
// After reset a sweep clears the occupancy bit of every slot; s_tready
// stays low until it ends. A result waiting in the output register does not
// block the next input beat; a new result waits for it to be taken.
module linear_probe_hash_table #(
  parameter int CAPACITY = lpht_pkg::CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // key[15:0], value[47:16], position[54:48], zero pad
  input  logic [1:0]  s_tuser,   // func[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // value_out, key_out, next_position, entry_count, zero pad
  output logic [2:0]  m_tuser,   // status[1:0], found[2]
  output logic        m_tlast    // scan_done
);

  lpht_pkg::cmd_t cmd;
  lpht_pkg::sts_t sts;

  logic [lpht_pkg::STATUS_W-1:0] out_status;
  logic                          out_found;
  logic [lpht_pkg::VAL_W-1:0]    out_value;
  logic [lpht_pkg::KEY_W-1:0]    out_key;
  logic [lpht_pkg::POS_W-1:0]    out_next_position;
  logic                          out_scan_done;
  logic [lpht_pkg::COUNT_W-1:0]  out_entry_count;

  lpht_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .in_func  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  lpht_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .sts               (sts),
    .in_func           (s_tuser),
    .in_key            (s_tdata[15:0]),
    .in_value          (s_tdata[47:16]),
    .in_position       (s_tdata[54:48]),
    .out_status        (out_status),
    .out_found         (out_found),
    .out_value         (out_value),
    .out_key           (out_key),
    .out_next_position (out_next_position),
    .out_scan_done     (out_scan_done),
    .out_entry_count   (out_entry_count)
  );

  assign m_tdata = {1'b0, out_entry_count, out_next_position, out_key, out_value};
  assign m_tuser = {out_found, out_status};
  assign m_tlast = out_scan_done;

endmodule
